// ----- rtl/core/assert_macros.svh -----
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RC4 drop keystream core.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/rc4d_pkg.sv -----
// -----------------------------------------------------------------------------
// RC4 drop keystream package
// Widths, register indexes, command encodings and shared types.
// -----------------------------------------------------------------------------
`default_nettype none

package rc4d_pkg;

  localparam int unsigned OUT_BYTES_DEF  = 16;
  localparam int unsigned SKIP_WIDTH_DEF = 16;

  localparam int unsigned PERM_DEPTH = 256;
  localparam int unsigned ADDR_W     = $clog2(PERM_DEPTH);
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned KEY_BYTES  = 16;
  localparam int unsigned KEY_SEL_W  = $clog2(KEY_BYTES);
  localparam int unsigned CFG_W      = 64;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned S_TDATA_W  = 16;
  localparam int unsigned M_TDATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 8'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_RD_J,
    ST_WR_I,
    ST_WR_J,
    ST_OUT,
    ST_RD_I
  } ctrl_state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,
    OP_FILL,
    OP_LOAD_SI,
    OP_SWAP_I,
    OP_SWAP_J,
    OP_OUT,
    OP_STEP_I
  } dp_op_e;

  // Source of the permutation read address.
  typedef enum logic [2:0] {
    RS_ZERO,
    RS_J_NEW,
    RS_I_NEXT,
    RS_ONE,
    RS_T
  } rsel_e;

  typedef struct packed {
    dp_op_e            op;
    rsel_e             rsel;
    logic              key_en;
    logic              out_load;
    logic [IDX_W-1:0]  out_index;
    logic              out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic i_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/rc4_drop_keystream_generator_core.sv -----
// -----------------------------------------------------------------------------
// RC4 drop keystream generator core: per request, fill, key schedule, drop, emit.
// Each further byte steps through RD_I, RD_J, WR_I, WR_J and OUT, and OUT holds while
// the output stalls; the read-then-write swap in the table sets this sequence.
// Reset clears control, indexes and key; the permutation table is not cleared.
// -----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rc4_drop_keystream_generator_core #(
  parameter int unsigned OUT_BYTES  = rc4d_pkg::OUT_BYTES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [rc4d_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [rc4d_pkg::CFG_W-1:0]       cfg_data_i,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [15:0] skip_count
  input  wire logic [rc4d_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [7:0] keystream_byte, [11:8] byte_index, [15:12] zero
  output logic [rc4d_pkg::M_TDATA_W-1:0]        m_axis_tdata,
  // last_byte
  output logic                                  m_axis_tlast
);

  rc4d_pkg::dp_cmd_t    dp_cmd;
  rc4d_pkg::dp_status_t dp_status;
  logic                 req_accept;
  logic                 fill_cmd;
  logic                 last_beat;
  logic                 last_idx_ok;

  assign cfg_ready_o = 1'b1;

  rc4d_ctrl #(
    .OUT_BYTES  (OUT_BYTES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .status_i      (dp_status),
    .cmd_o         (dp_cmd)
  );

  rc4d_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (dp_cmd),
    .status_o      (dp_status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  assign req_accept  = s_axis_tvalid && s_axis_tready;
  assign fill_cmd    = (dp_cmd.op == rc4d_pkg::OP_FILL);
  assign last_beat   = m_axis_tvalid && m_axis_tlast;
  assign last_idx_ok = (m_axis_tdata[11:8] == rc4d_pkg::IDX_W'(OUT_BYTES - 1));

  `ASSERT_NEXT(a_busy_after_request, clk_i, rst_ni, req_accept, !s_axis_tready, "still ready")
  `ASSERT_NEXT(a_fill_after_request, clk_i, rst_ni, req_accept, fill_cmd, "no table fill")
  `ASSERT_SAME(a_load_free, clk_i, rst_ni, dp_cmd.out_load, dp_status.out_free, "overrun")
  `ASSERT_SAME(a_last_index, clk_i, rst_ni, last_beat, last_idx_ok, "wrong last index")

endmodule

`default_nettype wire

// ----- rtl/core/rc4d_datapath.sv -----
// -----------------------------------------------------------------------------
// RC4 drop keystream datapath
// Permutation memory, index registers, swap bypass, key and output registers.
// -----------------------------------------------------------------------------
`default_nettype none

module rc4d_datapath (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  input  wire logic [rc4d_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [rc4d_pkg::CFG_W-1:0]           cfg_data_i,
  input  wire rc4d_pkg::dp_cmd_t                    cmd_i,
  output rc4d_pkg::dp_status_t                      status_o,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic [rc4d_pkg::M_TDATA_W-1:0]            m_axis_tdata,
  output logic                                      m_axis_tlast
);

  localparam int unsigned AW = rc4d_pkg::ADDR_W;
  localparam int unsigned BW = rc4d_pkg::BYTE_W;

  logic [BW-1:0] mem [rc4d_pkg::PERM_DEPTH];

  logic [rc4d_pkg::CFG_W-1:0] key_low_q, key_high_q;
  logic [AW-1:0] i_q, i_d, j_q, j_d;
  logic [BW-1:0] si_q, si_d, sj_q, sj_d;
  logic [BW-1:0] rdata_q, byp_data_q;
  logic          byp_q;
  logic [BW-1:0] rd_val, key_byte, key_add, j_new, t_addr;
  logic [AW-1:0] raddr, waddr;
  logic [BW-1:0] wdata;
  logic          we;
  logic          out_valid_q, out_last_q;
  logic [BW-1:0] out_byte_q;
  logic [rc4d_pkg::IDX_W-1:0] out_index_q;
  logic [2*rc4d_pkg::CFG_W-1:0] key_all;

  assign key_all  = {key_high_q, key_low_q};
  assign key_byte = key_all[i_q[rc4d_pkg::KEY_SEL_W-1:0]*BW +: BW];
  assign key_add  = cmd_i.key_en ? key_byte : '0;

  // A read that hit the address written in the same cycle returns the old
  // word, so the written byte is forwarded instead.
  assign rd_val = byp_q ? byp_data_q : rdata_q;
  assign j_new  = j_q + rd_val + key_add;
  assign t_addr = si_q + sj_q;

  always_comb begin
    unique case (cmd_i.rsel)
      rc4d_pkg::RS_ZERO:   raddr = '0;
      rc4d_pkg::RS_J_NEW:  raddr = j_new;
      rc4d_pkg::RS_I_NEXT: raddr = i_q + AW'(1);
      rc4d_pkg::RS_ONE:    raddr = AW'(1);
      rc4d_pkg::RS_T:      raddr = t_addr;
      default:             raddr = '0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = i_q;
    wdata = i_q;
    i_d   = i_q;
    j_d   = j_q;
    si_d  = si_q;
    sj_d  = sj_q;
    unique case (cmd_i.op)
      rc4d_pkg::OP_START: begin
        i_d = '0;
        j_d = '0;
      end
      rc4d_pkg::OP_FILL: begin
        we  = 1'b1;
        i_d = i_q + AW'(1);
      end
      rc4d_pkg::OP_LOAD_SI: begin
        si_d = rd_val;
        j_d  = j_new;
      end
      rc4d_pkg::OP_SWAP_I: begin
        we    = 1'b1;
        wdata = rd_val;
        sj_d  = rd_val;
      end
      rc4d_pkg::OP_SWAP_J: begin
        we    = 1'b1;
        waddr = j_q;
        wdata = si_q;
      end
      rc4d_pkg::OP_NONE, rc4d_pkg::OP_OUT, rc4d_pkg::OP_STEP_I: begin
      end
      default: begin
      end
    endcase
    if (cmd_i.rsel == rc4d_pkg::RS_I_NEXT) begin
      i_d = i_q + AW'(1);
    end else if (cmd_i.rsel == rc4d_pkg::RS_ONE) begin
      i_d = AW'(1);
      j_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    si_q       <= si_d;
    sj_q       <= sj_d;
    byp_data_q <= wdata;
    if (cmd_i.out_load) begin
      out_byte_q  <= rd_val;
      out_index_q <= cmd_i.out_index;
      out_last_q  <= cmd_i.out_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      j_q         <= '0;
      byp_q       <= 1'b0;
      out_valid_q <= 1'b0;
      key_low_q   <= '0;
      key_high_q  <= '0;
    end else begin
      i_q   <= i_d;
      j_q   <= j_d;
      byp_q <= we && (waddr == raddr);
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && (cfg_index_i == rc4d_pkg::CFG_KEY_LOW)) begin
        key_low_q <= cfg_data_i;
      end
      if (cfg_valid_i && (cfg_index_i == rc4d_pkg::CFG_KEY_HIGH)) begin
        key_high_q <= cfg_data_i;
      end
    end
  end

  assign status_o.i_last   = (i_q == '1);
  assign status_o.out_free = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(rc4d_pkg::M_TDATA_W - BW - rc4d_pkg::IDX_W)'(0),
                          out_index_q, out_byte_q};
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/core/rc4d_ctrl.sv -----
// -----------------------------------------------------------------------------
// RC4 drop keystream controller
// Sequences table fill, key schedule, discarded steps and output steps.
// -----------------------------------------------------------------------------
`default_nettype none

module rc4d_ctrl #(
  parameter int unsigned OUT_BYTES  = rc4d_pkg::OUT_BYTES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [rc4d_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  input  wire rc4d_pkg::dp_status_t             status_i,
  output rc4d_pkg::dp_cmd_t                     cmd_o
);

  localparam int unsigned SKIP_WIDTH = rc4d_pkg::SKIP_WIDTH_DEF;
  localparam int unsigned IW = rc4d_pkg::IDX_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(OUT_BYTES - 1);

  rc4d_pkg::ctrl_state_e state_q, state_d;
  logic                  sched_q, sched_d;
  logic [SKIP_WIDTH-1:0] skip_q, skip_d;
  logic [IW-1:0]         emit_q, emit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rc4d_pkg::ST_IDLE;
      sched_q <= 1'b0;
      skip_q  <= '0;
      emit_q  <= '0;
    end else begin
      state_q <= state_d;
      sched_q <= sched_d;
      skip_q  <= skip_d;
      emit_q  <= emit_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    sched_d          = sched_q;
    skip_d           = skip_q;
    emit_d           = emit_q;
    s_axis_tready    = 1'b0;
    cmd_o.op         = rc4d_pkg::OP_NONE;
    cmd_o.rsel       = rc4d_pkg::RS_ZERO;
    cmd_o.key_en     = 1'b0;
    cmd_o.out_load   = 1'b0;
    cmd_o.out_index  = emit_q;
    cmd_o.out_last   = (emit_q == LAST_IDX);
    unique case (state_q)
      rc4d_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.op = rc4d_pkg::OP_START;
          skip_d   = SKIP_WIDTH'(s_axis_tdata);
          emit_d   = '0;
          sched_d  = 1'b1;
          state_d  = rc4d_pkg::ST_FILL;
        end
      end
      rc4d_pkg::ST_FILL: begin
        // The read of entry zero in the final fill cycle primes the first swap.
        cmd_o.op = rc4d_pkg::OP_FILL;
        if (status_i.i_last) begin
          state_d = rc4d_pkg::ST_RD_J;
        end
      end
      rc4d_pkg::ST_RD_J: begin
        cmd_o.op     = rc4d_pkg::OP_LOAD_SI;
        cmd_o.rsel   = rc4d_pkg::RS_J_NEW;
        cmd_o.key_en = sched_q;
        state_d      = rc4d_pkg::ST_WR_I;
      end
      rc4d_pkg::ST_WR_I: begin
        cmd_o.op = rc4d_pkg::OP_SWAP_I;
        state_d  = rc4d_pkg::ST_WR_J;
      end
      rc4d_pkg::ST_WR_J: begin
        cmd_o.op = rc4d_pkg::OP_SWAP_J;
        if (sched_q) begin
          if (status_i.i_last) begin
            cmd_o.rsel = rc4d_pkg::RS_ONE;
            sched_d    = 1'b0;
          end else begin
            cmd_o.rsel = rc4d_pkg::RS_I_NEXT;
          end
          state_d = rc4d_pkg::ST_RD_J;
        end else if (skip_q != '0) begin
          cmd_o.rsel = rc4d_pkg::RS_I_NEXT;
          skip_d     = skip_q - SKIP_WIDTH'(1);
          state_d    = rc4d_pkg::ST_RD_J;
        end else begin
          cmd_o.rsel = rc4d_pkg::RS_T;
          state_d    = rc4d_pkg::ST_OUT;
        end
      end
      rc4d_pkg::ST_OUT: begin
        // The output address is read again each cycle while the output stalls.
        cmd_o.op   = rc4d_pkg::OP_OUT;
        cmd_o.rsel = rc4d_pkg::RS_T;
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          emit_d         = emit_q + IW'(1);
          if (emit_q == LAST_IDX) begin
            state_d = rc4d_pkg::ST_IDLE;
          end else begin
            state_d = rc4d_pkg::ST_RD_I;
          end
        end
      end
      rc4d_pkg::ST_RD_I: begin
        cmd_o.op   = rc4d_pkg::OP_STEP_I;
        cmd_o.rsel = rc4d_pkg::RS_I_NEXT;
        state_d    = rc4d_pkg::ST_RD_J;
      end
      default: begin
        state_d = rc4d_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
